FILE: hdl/tmr_pkg.sv
// tmr_pkg: shared widths, codes and types for the multi-timer table.
// No dependencies; compiled first.
package tmr_pkg;

    localparam int MAX_TIMERS_DEF = 16;
    localparam int MAX_RESULTS    = 16;

    localparam int OP_W     = 3;
    localparam int DELAY_W  = 32;
    localparam int ID_W     = 4;
    localparam int NOW_W    = 48;
    localparam int DUE_W    = 49;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int NRES_W   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_SET_ONESHOT  = 3'd0,
        OP_SET_PERIODIC = 3'd1,
        OP_CLEAR        = 3'd2,
        OP_UPDATE       = 3'd3,
        OP_COUNT        = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BAD_ID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET,
        S_CLR,
        S_UPD_RD,
        S_UPD_EV,
        S_UPD_FIN,
        S_CNT,
        S_BAD
    } t_state;

    typedef struct packed {
        logic               periodic;
        logic [DELAY_W-1:0] period;
        logic [DUE_W-1:0]   due;
    } t_slot;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    new_id;
        logic               fired;
        logic [ID_W-1:0]    fired_id;
        logic [COUNT_W-1:0] active_count;
        logic               last;
    } t_result;

endpackage

FILE: hdl/tmr_if.sv
// tmr_in_if / tmr_out_if: valid-ready channels for requests and results.
// Depends on tmr_pkg for field widths.
interface tmr_in_if;
    logic                         valid;
    logic                         ready;
    logic [tmr_pkg::OP_W-1:0]     op;
    logic [tmr_pkg::DELAY_W-1:0]  interval_ms;
    logic [tmr_pkg::ID_W-1:0]     clear_id;
    logic [tmr_pkg::NOW_W-1:0]    now_ms;

    modport source (output valid, op, interval_ms, clear_id, now_ms, input ready);
    modport sink   (input valid, op, interval_ms, clear_id, now_ms, output ready);
endinterface

interface tmr_out_if;
    logic                         valid;
    logic                         ready;
    logic [tmr_pkg::STATUS_W-1:0] status;
    logic [tmr_pkg::ID_W-1:0]     new_id;
    logic                         fired;
    logic [tmr_pkg::ID_W-1:0]     fired_id;
    logic [tmr_pkg::COUNT_W-1:0]  active_count;
    logic                         last;

    modport source (output valid, status, new_id, fired, fired_id, active_count, last,
                    input ready);
    modport sink   (input valid, status, new_id, fired, fired_id, active_count, last,
                    output ready);
endinterface

FILE: hdl/tmr_slot_mem.sv
// tmr_slot_mem: per-slot storage (periodic flag, period, due time).
// One write port, one registered read port. Depends on tmr_pkg.
module tmr_slot_mem #(
    parameter int DEPTH = tmr_pkg::MAX_TIMERS_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  tmr_pkg::t_slot  i_wdata,
    input  logic [IW-1:0]   i_raddr,
    output tmr_pkg::t_slot  o_rdata
);

    tmr_pkg::t_slot r_mem [DEPTH];
    tmr_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tmr_alu.sv
// tmr_alu: shared 49-bit adder (now + interval) and due-time compare.
// Depends on tmr_pkg.
module tmr_alu (
    input  logic [tmr_pkg::NOW_W-1:0]   i_now,
    input  logic [tmr_pkg::DELAY_W-1:0] i_addend,
    input  logic [tmr_pkg::DUE_W-1:0]   i_cmp,
    output logic [tmr_pkg::DUE_W-1:0]   o_sum,
    output logic                        o_ge
);

    assign o_sum = tmr_pkg::DUE_W'(i_now) + tmr_pkg::DUE_W'(i_addend);
    assign o_ge  = (tmr_pkg::DUE_W'(i_now) >= i_cmp);

endmodule

FILE: hdl/multi_timer_table_unit.sv
// multi_timer_table_unit: top level of the one-shot/periodic timer table.
// Depends on tmr_pkg, tmr_if, tmr_slot_mem, tmr_alu.
//
//  channel   | dir | interface          | transaction
//  ----------+-----+--------------------+-------------------------------------
//  i_in_ch   | in  | tmr_in_if.sink     | op, interval_ms, clear_id, now_ms
//  o_out_ch  | out | tmr_out_if.source  | status, new_id, fired, fired_id,
//            |     |                    | active_count, last
//
// Set, clear, unknown op: one result from S_SET, S_CLR or S_BAD. Count walks
// every allocated slot. Update: S_UPD_RD skips an inactive slot; an active
// slot also passes S_UPD_EV (slot memory read, then the shared add/compare).
// Input ready only in idle; a result in the output register does not block
// the next request. Output stalls hold an update walk only at a later fire.
// Reset is synchronous active low; it clears allocation and active flags.
module multi_timer_table_unit #(
    parameter int MAX_TIMERS = tmr_pkg::MAX_TIMERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmr_in_if.sink     i_in_ch,
    tmr_out_if.source  o_out_ch
);

    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);

    tmr_pkg::t_state                r_state, n_state;
    logic [tmr_pkg::OP_W-1:0]       r_op;
    logic [tmr_pkg::DELAY_W-1:0]    r_delay;
    logic [tmr_pkg::ID_W-1:0]       r_tid;
    logic [tmr_pkg::NOW_W-1:0]      r_now;
    logic [CW-1:0]                  r_used;
    logic [MAX_TIMERS-1:0]          r_active;
    logic [CW-1:0]                  r_idx;
    logic [CW-1:0]                  r_cnt;
    logic [tmr_pkg::NRES_W-1:0]     r_nres;
    logic                           r_pend_v;
    logic [IW-1:0]                  r_pend_id;
    logic                           r_out_v;
    tmr_pkg::t_result               r_out;

    logic                           in_fire;
    logic                           out_free;
    logic [IW-1:0]                  idx;
    logic [IW-1:0]                  tid_idx;
    logic                           walk_more;
    logic                           res_room;
    logic                           tid_ok;
    logic                           full;

    logic                           push;
    tmr_pkg::t_result               push_res;
    logic                           mem_we;
    logic [IW-1:0]                  mem_waddr;
    tmr_pkg::t_slot                 mem_wdata;
    tmr_pkg::t_slot                 mem_rdata;
    logic                           act_set;
    logic                           act_clr;
    logic [IW-1:0]                  act_idx;
    logic                           used_inc;
    logic                           idx_inc;
    logic                           cnt_inc;
    logic                           pend_load;
    logic [tmr_pkg::DELAY_W-1:0]    alu_addend;
    logic [tmr_pkg::DUE_W-1:0]      alu_sum;
    logic                           alu_ge;

    assign i_in_ch.ready = (r_state == tmr_pkg::S_IDLE);
    assign in_fire       = i_in_ch.valid && i_in_ch.ready;
    assign out_free      = !r_out_v || o_out_ch.ready;
    assign idx           = r_idx[IW-1:0];
    assign tid_idx       = IW'(r_tid);
    assign walk_more     = (r_idx < r_used);
    assign res_room      = (32'(r_nres) < tmr_pkg::MAX_RESULTS);
    assign tid_ok        = (32'(r_tid) < 32'(r_used));
    assign full          = (32'(r_used) >= MAX_TIMERS);
    assign alu_addend    = (r_state == tmr_pkg::S_SET) ? r_delay : mem_rdata.period;

    tmr_slot_mem #(
        .DEPTH (MAX_TIMERS),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (idx),
        .o_rdata (mem_rdata)
    );

    tmr_alu u_alu (
        .i_now    (r_now),
        .i_addend (alu_addend),
        .i_cmp    (mem_rdata.due),
        .o_sum    (alu_sum),
        .o_ge     (alu_ge)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmr_pkg::S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in_ch.op)
                        tmr_pkg::OP_SET_ONESHOT,
                        tmr_pkg::OP_SET_PERIODIC: n_state = tmr_pkg::S_SET;
                        tmr_pkg::OP_CLEAR:        n_state = tmr_pkg::S_CLR;
                        tmr_pkg::OP_UPDATE:       n_state = tmr_pkg::S_UPD_RD;
                        tmr_pkg::OP_COUNT:        n_state = tmr_pkg::S_CNT;
                        default:                  n_state = tmr_pkg::S_BAD;
                    endcase
                end
            end
            tmr_pkg::S_SET, tmr_pkg::S_CLR, tmr_pkg::S_BAD, tmr_pkg::S_UPD_FIN: begin
                if (out_free) begin
                    n_state = tmr_pkg::S_IDLE;
                end
            end
            tmr_pkg::S_UPD_RD: begin
                if (!walk_more || !res_room) begin
                    n_state = tmr_pkg::S_UPD_FIN;
                end else if (r_active[idx]) begin
                    n_state = tmr_pkg::S_UPD_EV;
                end
            end
            tmr_pkg::S_UPD_EV: begin
                if (!(alu_ge && r_pend_v && !out_free)) begin
                    n_state = tmr_pkg::S_UPD_RD;
                end
            end
            tmr_pkg::S_CNT: begin
                if (!walk_more && out_free) begin
                    n_state = tmr_pkg::S_IDLE;
                end
            end
            default: n_state = tmr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        push      = 1'b0;
        push_res  = '0;
        mem_we    = 1'b0;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        act_set   = 1'b0;
        act_clr   = 1'b0;
        act_idx   = idx;
        used_inc  = 1'b0;
        idx_inc   = 1'b0;
        cnt_inc   = 1'b0;
        pend_load = 1'b0;
        unique case (r_state)
            tmr_pkg::S_IDLE: ;
            tmr_pkg::S_SET: begin
                if (out_free) begin
                    push          = 1'b1;
                    push_res.last = 1'b1;
                    if (full) begin
                        push_res.status = tmr_pkg::ST_FULL;
                    end else begin
                        push_res.new_id    = tmr_pkg::ID_W'(r_used);
                        mem_we             = 1'b1;
                        mem_waddr          = r_used[IW-1:0];
                        mem_wdata.periodic = (r_op == tmr_pkg::OP_SET_PERIODIC);
                        mem_wdata.period   = r_delay;
                        mem_wdata.due      = alu_sum;
                        act_set            = 1'b1;
                        act_idx            = r_used[IW-1:0];
                        used_inc           = 1'b1;
                    end
                end
            end
            tmr_pkg::S_CLR: begin
                if (out_free) begin
                    push          = 1'b1;
                    push_res.last = 1'b1;
                    if (tid_ok) begin
                        act_clr = 1'b1;
                        act_idx = tid_idx;
                    end else begin
                        push_res.status = tmr_pkg::ST_BAD_ID;
                    end
                end
            end
            tmr_pkg::S_UPD_RD: begin
                if (walk_more && res_room && !r_active[idx]) begin
                    idx_inc = 1'b1;
                end
            end
            tmr_pkg::S_UPD_EV: begin
                if (!alu_ge) begin
                    idx_inc = 1'b1;
                end else if (!(r_pend_v && !out_free)) begin
                    if (r_pend_v) begin
                        push              = 1'b1;
                        push_res.fired    = 1'b1;
                        push_res.fired_id = tmr_pkg::ID_W'(r_pend_id);
                    end
                    pend_load = 1'b1;
                    idx_inc   = 1'b1;
                    if (mem_rdata.periodic) begin
                        mem_we        = 1'b1;
                        mem_wdata.due = alu_sum;
                    end else begin
                        act_clr = 1'b1;
                    end
                end
            end
            tmr_pkg::S_UPD_FIN: begin
                if (out_free) begin
                    push              = 1'b1;
                    push_res.last     = 1'b1;
                    push_res.fired    = r_pend_v;
                    push_res.fired_id = r_pend_v ? tmr_pkg::ID_W'(r_pend_id) : '0;
                end
            end
            tmr_pkg::S_CNT: begin
                if (walk_more) begin
                    idx_inc = 1'b1;
                    cnt_inc = r_active[idx];
                end else if (out_free) begin
                    push                  = 1'b1;
                    push_res.last         = 1'b1;
                    push_res.active_count = tmr_pkg::COUNT_W'(r_cnt);
                end
            end
            tmr_pkg::S_BAD: begin
                if (out_free) begin
                    push          = 1'b1;
                    push_res.last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tmr_pkg::S_IDLE;
            r_used   <= '0;
            r_active <= '0;
            r_nres   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_op     <= i_in_ch.op;
                r_delay  <= i_in_ch.interval_ms;
                r_tid    <= i_in_ch.clear_id;
                r_now    <= i_in_ch.now_ms;
                r_idx    <= '0;
                r_cnt    <= '0;
                r_nres   <= '0;
                r_pend_v <= 1'b0;
            end else begin
                if (idx_inc) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (cnt_inc) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (pend_load) begin
                    r_pend_v  <= 1'b1;
                    r_pend_id <= idx;
                    r_nres    <= r_nres + 1'b1;
                end
            end
            if (used_inc) begin
                r_used <= r_used + 1'b1;
            end
            if (act_set) begin
                r_active[act_idx] <= 1'b1;
            end else if (act_clr) begin
                r_active[act_idx] <= 1'b0;
            end
            if (push) begin
                r_out_v <= 1'b1;
                r_out   <= push_res;
            end else if (o_out_ch.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_ch.valid        = r_out_v;
    assign o_out_ch.status       = r_out.status;
    assign o_out_ch.new_id       = r_out.new_id;
    assign o_out_ch.fired        = r_out.fired;
    assign o_out_ch.fired_id     = r_out.fired_id;
    assign o_out_ch.active_count = r_out.active_count;
    assign o_out_ch.last         = r_out.last;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= MAX_TIMERS)
        else $error("slot allocation beyond table size");

    a_active_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active >> r_used) == '0)
        else $error("active flag on an unallocated slot");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_used != $past(r_used)) |-> (r_used == $past(r_used) + 1'b1))
        else $error("allocation count moved by other than one");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && r_state != tmr_pkg::S_IDLE) |->
            (r_state == tmr_pkg::S_UPD_RD || r_state == tmr_pkg::S_UPD_EV ||
             r_state == tmr_pkg::S_UPD_FIN))
        else $error("pending fire outside an update walk");

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_nres) <= tmr_pkg::MAX_RESULTS)
        else $error("more fires than results per update");

endmodule
